>>> src/msgenc_pkg.sv
// Shared types and constants for the MessagePack token encoder.
// No dependencies; imported by every module of the encoder.
package msgenc_pkg;

    localparam int unsigned FIFO_DEPTH = 4;

    // Token kinds on the op input.
    localparam logic [3:0] OP_NIL     = 4'd0;
    localparam logic [3:0] OP_BOOL    = 4'd1;
    localparam logic [3:0] OP_INT     = 4'd2;
    localparam logic [3:0] OP_DOUBLE  = 4'd3;
    localparam logic [3:0] OP_STR     = 4'd4;
    localparam logic [3:0] OP_BIN     = 4'd5;
    localparam logic [3:0] OP_ARRAY   = 4'd6;
    localparam logic [3:0] OP_MAP     = 4'd7;
    localparam logic [3:0] OP_PAYLOAD = 4'd8;

    // Format code bytes.
    localparam logic [7:0] CODE_NIL     = 8'hc0;
    localparam logic [7:0] CODE_FALSE   = 8'hc2;
    localparam logic [7:0] CODE_TRUE    = 8'hc3;
    localparam logic [7:0] CODE_UINT8   = 8'hcc;
    localparam logic [7:0] CODE_INT8    = 8'hd0;
    localparam logic [7:0] CODE_NEGFIX  = 8'he0;
    localparam logic [7:0] CODE_STR32   = 8'hdb;
    localparam logic [7:0] CODE_BIN32   = 8'hc6;
    localparam logic [7:0] CODE_ARRAY32 = 8'hdd;
    localparam logic [7:0] CODE_MAP32   = 8'hdf;
    localparam logic [7:0] CODE_FLOAT64 = 8'hcb;
    localparam logic [7:0] FIXINT_MAX   = 8'h7f;

    // One classified token: the leading byte, then nbytes bytes taken from
    // the top of data, most significant first.
    typedef struct packed {
        logic [7:0]  code;
        logic [63:0] data;
        logic [3:0]  nbytes;
    } token_t;

endpackage

>>> src/msgenc_front.sv
// Front end: accepts input beats and classifies each into a token_t.
// Depends on msgenc_pkg.
module msgenc_front
    import msgenc_pkg::*;
(
    input  logic        push,
    input  logic        full,
    input  logic [3:0]  op,
    input  logic [63:0] value,
    output logic        wr_en,
    output token_t      wr_token
);

    logic        op_ok;
    logic [7:0]  code;
    logic [3:0]  nbytes;
    logic        neg;

    assign neg = value[63];

    always_comb
    begin
        op_ok  = 1'b1;
        code   = CODE_NIL;
        nbytes = 4'd0;
        case (op)
            OP_NIL:
            begin
                code = CODE_NIL;
            end
            OP_BOOL:
            begin
                code = value[0] ? CODE_TRUE : CODE_FALSE;
            end
            OP_INT:
            begin
                if (!neg)
                begin
                    if (value[63:7] == '0)
                    begin
                        code = value[7:0] & FIXINT_MAX;
                    end
                    else if (value[63:8] == '0)
                    begin
                        code   = CODE_UINT8;
                        nbytes = 4'd1;
                    end
                    else if (value[63:16] == '0)
                    begin
                        code   = CODE_UINT8 + 8'd1;
                        nbytes = 4'd2;
                    end
                    else if (value[63:32] == '0)
                    begin
                        code   = CODE_UINT8 + 8'd2;
                        nbytes = 4'd4;
                    end
                    else
                    begin
                        code   = CODE_UINT8 + 8'd3;
                        nbytes = 4'd8;
                    end
                end
                else
                begin
                    // A negative value fits a width when its sign bit and all bits
                    // above it are ones.
                    if (&value[63:5])
                    begin
                        code = CODE_NEGFIX | {3'b000, value[4:0]};
                    end
                    else if (&value[63:7])
                    begin
                        code   = CODE_INT8;
                        nbytes = 4'd1;
                    end
                    else if (&value[63:15])
                    begin
                        code   = CODE_INT8 + 8'd1;
                        nbytes = 4'd2;
                    end
                    else if (&value[63:31])
                    begin
                        code   = CODE_INT8 + 8'd2;
                        nbytes = 4'd4;
                    end
                    else
                    begin
                        code   = CODE_INT8 + 8'd3;
                        nbytes = 4'd8;
                    end
                end
            end
            OP_DOUBLE:
            begin
                code   = CODE_FLOAT64;
                nbytes = 4'd8;
            end
            OP_STR:
            begin
                code   = CODE_STR32;
                nbytes = 4'd4;
            end
            OP_BIN:
            begin
                code   = CODE_BIN32;
                nbytes = 4'd4;
            end
            OP_ARRAY:
            begin
                code   = CODE_ARRAY32;
                nbytes = 4'd4;
            end
            OP_MAP:
            begin
                code   = CODE_MAP32;
                nbytes = 4'd4;
            end
            OP_PAYLOAD:
            begin
                code = value[7:0];
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // Left-align the operand bytes so the back end always shifts from the top.
    always_comb
    begin
        wr_token.code   = code;
        wr_token.nbytes = nbytes;
        case (nbytes)
            4'd1:    wr_token.data = {value[7:0], 56'd0};
            4'd2:    wr_token.data = {value[15:0], 48'd0};
            4'd4:    wr_token.data = {value[31:0], 32'd0};
            4'd8:    wr_token.data = value;
            default: wr_token.data = '0;
        endcase
    end

    // Unused op codes are accepted and dropped.
    assign wr_en = push && !full && op_ok;

endmodule

>>> src/msgenc_fifo.sv
// Short token queue between the front and back ends.
// Depends on msgenc_pkg for token_t.
module msgenc_fifo
    import msgenc_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  token_t wr_token,
    input  logic   rd_en,
    output token_t rd_token,
    output logic   full,
    output logic   empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    token_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && !empty;
    assign rd_token = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_token;
        end
    end

endmodule

>>> src/msgenc_back.sv
// Back end: serializes queued tokens into one output byte per beat.
// Depends on msgenc_pkg for token_t.
module msgenc_back
    import msgenc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  token_t     rd_token,
    input  logic       q_empty,
    output logic       rd_en,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic       last
);

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        last_reg;
    logic        last_next;
    logic [63:0] data_reg;
    logic [63:0] data_next;
    logic [3:0]  rem_reg;
    logic [3:0]  rem_next;
    logic        advance;

    // The output register can take a new byte when it is empty or being popped.
    assign advance = !out_valid_reg || pop;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        data_next      = data_reg;
        rem_next       = rem_reg;
        rd_en          = 1'b0;
        if (advance)
        begin
            if (rem_reg != 4'd0)
            begin
                out_valid_next = 1'b1;
                byte_next      = data_reg[63:56];
                last_next      = (rem_reg == 4'd1);
                data_next      = {data_reg[55:0], 8'd0};
                rem_next       = rem_reg - 4'd1;
            end
            else if (!q_empty)
            begin
                rd_en          = 1'b1;
                out_valid_next = 1'b1;
                byte_next      = rd_token.code;
                last_next      = (rd_token.nbytes == 4'd0);
                data_next      = rd_token.data;
                rem_next       = rd_token.nbytes;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        data_reg <= data_next;
    end

    assign empty    = !out_valid_reg;
    assign out_byte = byte_reg;
    assign last     = last_reg;

endmodule

>>> src/msgpack_token_encoder_core.sv
// Top level of the MessagePack token encoder: front end, token queue, back end.
// Depends on msgenc_pkg, msgenc_front, msgenc_fifo and msgenc_back.
//
//   channel   handshake     payload            direction
//   input     push / full   op[3:0], value[63:0]  in
//   result    pop / empty   out_byte[7:0], last   out
//
// The front end classifies a token in the cycle it is accepted; the token is
// written to the queue, and its first byte then moves to the output register.
// A token leaves as 1 to 9 bytes, one per cycle while the receiver pops; the byte
// serializer sets the sustained rate: nine-byte tokens leave one per nine bytes.
// The queue of FIFO_DEPTH tokens lets input beats continue while results stall.
// Reset empties the queue and the output register; no clearing pass is needed.
module msgpack_token_encoder_core
    import msgenc_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [3:0]  op,
    input  logic [63:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last
);

    logic   wr_en;
    token_t wr_token;
    token_t rd_token;
    logic   rd_en;
    logic   q_empty;

    msgenc_front u_front (
        .push     (push),
        .full     (full),
        .op       (op),
        .value    (value),
        .wr_en    (wr_en),
        .wr_token (wr_token)
    );

    msgenc_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_token (wr_token),
        .rd_en    (rd_en),
        .rd_token (rd_token),
        .full     (full),
        .empty    (q_empty)
    );

    msgenc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_token (rd_token),
        .q_empty  (q_empty),
        .rd_en    (rd_en),
        .pop      (pop),
        .empty    (empty),
        .out_byte (out_byte),
        .last     (last)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for msgpack_token_encoder_core: random and directed tokens in,
// encoded bytes out, each byte compared with a predicted byte stream.
// Depends on msgenc_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top
    import msgenc_pkg::*;
;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TARGET_ITEMS = 360;
    localparam int QUIET_ITEMS  = 320;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    // Predicts the byte stream of each accepted token and checks what comes out.
    class msgpack_byte_checker;
        enc_byte_t expected_bytes[$];
        int        mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void add_code(ref enc_byte_t run[$], input logic [7:0] code);
            enc_byte_t eb;
            eb.data = code;
            eb.last = 1'b0;
            run = {run, eb};
        endfunction

        // Appends the low nbytes of word, most significant byte first.
        function void add_be(ref enc_byte_t run[$], input logic [63:0] word, input int nbytes);
            for (int i = nbytes - 1; i >= 0; i--)
            begin
                add_code(run, word[i*8 +: 8]);
            end
        endfunction

        function void encode_integer(ref enc_byte_t run[$], input logic [63:0] v);
            if (!v[63])
            begin
                if (v <= {56'd0, FIXINT_MAX})
                    add_code(run, v[7:0]);
                else if (v <= 64'hff)
                begin
                    add_code(run, CODE_UINT8);
                    add_be(run, v, 1);
                end
                else if (v <= 64'hffff)
                begin
                    add_code(run, CODE_UINT8 + 8'd1);
                    add_be(run, v, 2);
                end
                else if (v <= 64'hffff_ffff)
                begin
                    add_code(run, CODE_UINT8 + 8'd2);
                    add_be(run, v, 4);
                end
                else
                begin
                    add_code(run, CODE_UINT8 + 8'd3);
                    add_be(run, v, 8);
                end
            end
            else
            begin
                if (v >= 64'hffff_ffff_ffff_ffe0)
                    add_code(run, CODE_NEGFIX | {3'd0, v[4:0]});
                else if (v >= 64'hffff_ffff_ffff_ff80)
                begin
                    add_code(run, CODE_INT8);
                    add_be(run, v, 1);
                end
                else if (v >= 64'hffff_ffff_ffff_8000)
                begin
                    add_code(run, CODE_INT8 + 8'd1);
                    add_be(run, v, 2);
                end
                else if (v >= 64'hffff_ffff_8000_0000)
                begin
                    add_code(run, CODE_INT8 + 8'd2);
                    add_be(run, v, 4);
                end
                else
                begin
                    add_code(run, CODE_INT8 + 8'd3);
                    add_be(run, v, 8);
                end
            end
        endfunction

        function void note_token(input logic [3:0] kind, input logic [63:0] v);
            enc_byte_t run[$];
            case (kind)
                OP_NIL:     add_code(run, CODE_NIL);
                OP_BOOL:    add_code(run, v[0] ? CODE_TRUE : CODE_FALSE);
                OP_INT:     encode_integer(run, v);
                OP_DOUBLE:
                begin
                    add_code(run, CODE_FLOAT64);
                    add_be(run, v, 8);
                end
                OP_STR, OP_BIN, OP_ARRAY, OP_MAP:
                begin
                    case (kind)
                        OP_STR:   add_code(run, CODE_STR32);
                        OP_BIN:   add_code(run, CODE_BIN32);
                        OP_ARRAY: add_code(run, CODE_ARRAY32);
                        default:  add_code(run, CODE_MAP32);
                    endcase
                    add_be(run, {32'd0, v[31:0]}, 4);
                end
                OP_PAYLOAD: add_code(run, v[7:0]);
                default:    ;
            endcase
            if (run.size() > 0)
            begin
                run[run.size() - 1].last = 1'b1;
                expected_bytes = {expected_bytes, run};
            end
        endfunction

        function void check_byte(input logic [7:0] data, input logic last);
            enc_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: out_byte=%02h last=%0b", data, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected out_byte=%02h last=%0b, got out_byte=%02h last=%0b",
                             want.data, want.last, data, last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [3:0]  op = OP_NIL;
    logic [63:0] value = 64'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        last;

    msgpack_byte_checker sb;
    int  cycles = 0;
    int  items_sent = 0;
    int  tx_idle_pct = 0;
    bit  quiet = 1'b0;
    int  rx_hold = 0;
    int  rx_mode_left = 0;
    int  rx_idle_pct = 0;

    msgpack_token_encoder_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .op       (op),
        .value    (value),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Both beats are observed on the values present just before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_token(op, value);
            if (pop && !empty)
                sb.check_byte(out_byte, last);
        end
    end

    // Receiver: stall bursts whose density changes from stretch to stretch.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode_left = $urandom_range(50, 200);
            case ($urandom_range(2))
                0:       rx_idle_pct = 0;
                1:       rx_idle_pct = 15;
                default: rx_idle_pct = 40;
            endcase
        end
        else
            rx_mode_left--;
        if (quiet)
            rx_hold = 0;
        if (rx_hold > 0)
        begin
            rx_hold--;
            pop <= 1'b0;
        end
        else if (!quiet && $urandom_range(99) < rx_idle_pct)
        begin
            rx_hold = $urandom_range(1, 9) - 1;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    task automatic send_token(input logic [3:0] kind, input logic [63:0] operand);
        op    <= kind;
        value <= operand;
        push  <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (kind < OP_UNUSED_LO)
            items_sent++;
        if (items_sent % 30 == 0)
            tx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 50);
        if (!quiet && $urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9))
                @(posedge clk);
        end
    endtask

    // The extra edge lets the monitor note the last accepted beat before the
    // pending count is trusted.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [63:0] random_integer();
        logic [63:0] mag;
        mag = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(1))
            mag = ~mag;
        return mag;
    endfunction

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_directed();
        send_token(OP_NIL, 64'hffff_ffff_ffff_ffff);
        send_token(OP_BOOL, 64'hffff_ffff_ffff_fffe);
        send_token(OP_BOOL, 64'h0000_0000_0000_0001);
        send_token(OP_INT, 64'd127);
        send_token(OP_INT, 64'd128);
        send_token(OP_INT, 64'd255);
        send_token(OP_INT, 64'd65535);
        send_token(OP_INT, 64'hffff_ffff);
        send_token(OP_INT, 64'h1_0000_0000);
        send_token(OP_INT, -64'sd32);
        send_token(OP_INT, -64'sd33);
        send_token(OP_INT, -64'sd128);
        send_token(OP_INT, -64'sd129);
        send_token(OP_INT, -64'sd32768);
        send_token(OP_INT, 64'hffff_ffff_8000_0000);
        send_token(OP_INT, 64'h8000_0000_0000_0000);
        send_token(OP_DOUBLE, 64'hc00d_f3b6_45a1_cac1);
        send_token(OP_STR, 64'hdead_beef_0000_0003);
        send_token(OP_BIN, 64'h0000_0000_ffff_ffff);
        send_token(OP_ARRAY, 64'h0000_0001_8000_0000);
        send_token(OP_MAP, 64'd0);
        send_token(OP_PAYLOAD, 64'hffff_ffff_ffff_ff5a);
        send_token(OP_UNUSED_HI, 64'h0123_4567_89ab_cdef);
    endtask

    // Mostly well-formed groups: a header followed by its payload bytes or
    // elements, plus loose tokens and some unused op codes as noise.
    task automatic send_random();
        int          pick;
        int          count;
        logic [3:0]  kind;
        logic [63:0] len;
        while (items_sent < TARGET_ITEMS)
        begin
            if (items_sent >= QUIET_ITEMS)
                quiet = 1'b1;
            if (items_sent >= 180 && items_sent < 184)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 35)
                send_token(OP_INT, random_integer());
            else if (pick < 45)
                send_token(OP_DOUBLE, random_word());
            else if (pick < 55)
                send_token($urandom_range(1) ? OP_BOOL : OP_NIL, random_word());
            else if (pick < 78)
            begin
                kind = OP_STR + 4'($urandom_range(3));
                count = $urandom_range(0, 3);
                len = {$urandom_range(1) ? 32'($urandom) : 32'd0, 32'(count)};
                if ($urandom_range(4) == 0)
                begin
                    len = random_word();
                    count = 0;
                end
                send_token(kind, len);
                if (kind == OP_MAP)
                    count = count * 2;
                repeat (count)
                begin
                    if (kind == OP_STR || kind == OP_BIN)
                        send_token(OP_PAYLOAD, random_word());
                    else
                        send_token(OP_INT, random_integer());
                end
            end
            else if (pick < 92)
                send_token(OP_PAYLOAD, random_word());
            else
                send_token(4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), random_word());
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        wait_drained();
        send_random();
        quiet = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
